// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must hold in the cycle after reset was high.
`define ASSERT_AFTER_RESET(label, cons, msg) \
  label: assert property (@(posedge clk) $past(rst) |-> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/pls_pkg.sv -----
// Shared types and codes of the positional list store.
`default_nettype none

package pls_pkg;

  localparam int DEF_CAPACITY = 32;

  localparam logic [1:0] KIND_INSERT  = 2'd0;
  localparam logic [1:0] KIND_DELETE  = 2'd1;
  localparam logic [1:0] KIND_DISPLAY = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [5:0]         position;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [5:0]         count;
    logic signed [31:0] element;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic val;
    logic nxt;
    logic prv;
  } node_we_t;

  typedef struct packed {
    logic fetch;
    logic take;
    logic give;
  } fs_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pls_node_mem.sv -----
// Node memory: value, next link and previous link per slot, field write enables.
`default_nettype none

module pls_node_mem #(
  parameter int DEPTH = pls_pkg::DEF_CAPACITY,
  parameter int SW    = $clog2(DEPTH)
) (
  input  wire                     clk,
  input  wire                     rd_en,
  input  wire  [SW-1:0]           rd_addr,
  output logic signed [31:0]      rd_val,
  output logic [SW-1:0]           rd_nxt,
  output logic [SW-1:0]           rd_prv,
  input  pls_pkg::node_we_t       we,
  input  wire  [SW-1:0]           wr_addr,
  input  wire  signed [31:0]      wr_val,
  input  wire  [SW-1:0]           wr_nxt,
  input  wire  [SW-1:0]           wr_prv
);
  import pls_pkg::*;

  logic signed [31:0] val_mem [DEPTH];
  logic [SW-1:0]      nxt_mem [DEPTH];
  logic [SW-1:0]      prv_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we.val) begin
      val_mem[wr_addr] <= wr_val;
    end
    if (we.nxt) begin
      nxt_mem[wr_addr] <= wr_nxt;
    end
    if (we.prv) begin
      prv_mem[wr_addr] <= wr_prv;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_val <= val_mem[rd_addr];
      rd_nxt <= nxt_mem[rd_addr];
      rd_prv <= prv_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/pls_free_stack.sv -----
// Free-slot allocator: stack of released slots plus a counter of never-used slots.
`default_nettype none

module pls_free_stack #(
  parameter int DEPTH = pls_pkg::DEF_CAPACITY,
  parameter int SW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire                clk,
  input  wire                rst,
  input  pls_pkg::fs_ctl_t   ctl,
  input  wire  [SW-1:0]      give_slot,
  output logic [SW-1:0]      slot
);
  import pls_pkg::*;

  logic [SW-1:0] stack_mem [DEPTH];
  logic [SW-1:0] rdata;
  logic [CW-1:0] cnt;
  logic [CW-1:0] fresh;
  logic [CW-1:0] cnt_m1;

  assign cnt_m1 = cnt - CW'(1);
  assign slot   = (cnt != '0) ? rdata : fresh[SW-1:0];

  always_ff @(posedge clk) begin
    if (ctl.give && cnt != CW'(DEPTH)) begin
      stack_mem[cnt[SW-1:0]] <= give_slot;
    end
    if (ctl.fetch) begin
      rdata <= stack_mem[cnt_m1[SW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      fresh <= '0;
    end else if (ctl.take) begin
      if (cnt != '0) begin
        cnt <= cnt_m1;
      end else begin
        fresh <= fresh + CW'(1);
      end
    end else if (ctl.give && cnt != CW'(DEPTH)) begin
      cnt <= cnt + CW'(1);
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/positional_list_store.sv -----
// Positional list store top level: sequencer, node memory and free-slot allocator.
// Holds up to CAPACITY signed 32-bit words as a circular doubly linked list in a
// synchronous node memory; no clearing pass is needed after reset. One request is
// handled at a time. Reaching position p walks p-1 links at one node-memory read
// per cycle (none for an end insertion); an insert or a delete then makes any relink
// writes through the single node write port, then commit and response. A display
// streams one word per cycle from the head while the output register is free. A
// finished response waits in the output register while the next request is taken.
`default_nettype none

module positional_list_store #(
  parameter int CAPACITY = pls_pkg::DEF_CAPACITY
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 req_valid,
  output logic                req_ready,
  input  pls_pkg::in_word_t   req,
  output logic                rsp_valid,
  input  wire                 rsp_ready,
  output pls_pkg::out_word_t  rsp
);
  import pls_pkg::*;

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ((CW > 6) ? CW : 6) + 1;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_WALK   = 10'b0000000010,
    S_INS_A  = 10'b0000000100,
    S_INS_B  = 10'b0000001000,
    S_INS_C  = 10'b0000010000,
    S_DEL_A  = 10'b0000100000,
    S_DEL_B  = 10'b0001000000,
    S_COMMIT = 10'b0010000000,
    S_RESP   = 10'b0100000000,
    S_DISP   = 10'b1000000000
  } state_t;

  state_t             state;
  logic               op_ins;
  logic [5:0]         pos;
  logic signed [31:0] val;
  logic [SW-1:0]      cur;
  logic [5:0]         steps;
  logic [CW-1:0]      rem;
  logic [SW-1:0]      after;
  logic [SW-1:0]      prior;
  logic [SW-1:0]      nslot;
  logic [CW-1:0]      count;
  logic [SW-1:0]      head;
  logic [1:0]         res_status;

  logic               rd_en;
  logic [SW-1:0]      rd_addr;
  logic signed [31:0] rd_val;
  logic [SW-1:0]      rd_nxt;
  logic [SW-1:0]      rd_prv;
  node_we_t           we;
  logic [SW-1:0]      wr_addr;
  logic [SW-1:0]      wr_nxt;
  logic [SW-1:0]      wr_prv;
  fs_ctl_t            fs_ctl;
  logic [SW-1:0]      fs_slot;

  logic               accept;
  logic               out_free;
  logic               rsp_load;
  logic               empty;
  logic [PW-1:0]      pos_w;
  logic [PW-1:0]      cnt_w;
  logic               at_end;
  logic               ins_bad;
  logic               del_bad;
  logic               full;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign out_free  = !rsp_valid || rsp_ready;
  assign rsp_load  = out_free && ((state == S_RESP) || (state == S_DISP));
  assign empty     = (count == '0);
  assign pos_w     = PW'(req.position);
  assign cnt_w     = PW'(count);
  assign at_end    = (pos_w == cnt_w + PW'(1));
  assign ins_bad   = (req.position == '0) || (pos_w > cnt_w + PW'(1));
  assign del_bad   = (req.position == '0) || (pos_w > cnt_w);
  assign full      = (count == CW'(CAPACITY));

  pls_node_mem #(.DEPTH(CAPACITY), .SW(SW)) u_node (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_val  (rd_val),
    .rd_nxt  (rd_nxt),
    .rd_prv  (rd_prv),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_val  (val),
    .wr_nxt  (wr_nxt),
    .wr_prv  (wr_prv)
  );

  pls_free_stack #(.DEPTH(CAPACITY), .SW(SW), .CW(CW)) u_free (
    .clk       (clk),
    .rst       (rst),
    .ctl       (fs_ctl),
    .give_slot (cur),
    .slot      (fs_slot)
  );

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cur;
    case (state)
      S_IDLE: begin
        rd_en   = 1'b1;
        rd_addr = head;
      end
      S_WALK: begin
        rd_en   = (steps != '0);
        rd_addr = rd_nxt;
      end
      S_DISP: begin
        rd_en   = out_free && (rem != CW'(1));
        rd_addr = rd_nxt;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    we      = '0;
    wr_addr = nslot;
    wr_nxt  = after;
    wr_prv  = prior;
    case (state)
      S_INS_A: begin
        we = '{val: 1'b1, nxt: 1'b1, prv: 1'b1};
        if (empty) begin
          wr_nxt = nslot;
          wr_prv = nslot;
        end
      end
      S_INS_B: begin
        we.nxt  = 1'b1;
        wr_addr = prior;
        wr_nxt  = nslot;
      end
      S_INS_C: begin
        we.prv  = 1'b1;
        wr_addr = after;
        wr_prv  = nslot;
      end
      S_DEL_A: begin
        we.nxt  = 1'b1;
        wr_addr = prior;
      end
      S_DEL_B: begin
        we.prv  = 1'b1;
        wr_addr = after;
      end
      default: begin
        we = '0;
      end
    endcase
  end

  always_comb begin
    fs_ctl.fetch = accept && (req.kind == KIND_INSERT);
    fs_ctl.take  = (state == S_COMMIT) && op_ins;
    fs_ctl.give  = (state == S_COMMIT) && !op_ins;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      head      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_ins <= (req.kind == KIND_INSERT);
            pos    <= req.position;
            val    <= req.value;
            cur    <= head;
            steps  <= at_end ? '0 : req.position - 6'd1;
            rem    <= count;
            case (req.kind)
              KIND_INSERT: begin
                if (ins_bad) begin
                  res_status <= ST_INVALID;
                  state      <= S_RESP;
                end else if (full) begin
                  res_status <= ST_FULL;
                  state      <= S_RESP;
                end else begin
                  state <= S_WALK;
                end
              end
              KIND_DELETE: begin
                if (del_bad) begin
                  res_status <= ST_INVALID;
                  state      <= S_RESP;
                end else begin
                  state <= S_WALK;
                end
              end
              KIND_DISPLAY: begin
                if (empty) begin
                  res_status <= ST_OK;
                  state      <= S_RESP;
                end else begin
                  state <= S_DISP;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_WALK: begin
          if (steps != '0) begin
            cur   <= rd_nxt;
            steps <= steps - 6'd1;
          end else if (op_ins) begin
            after  <= cur;
            prior  <= rd_prv;
            nslot  <= fs_slot;
            state  <= S_INS_A;
          end else begin
            after  <= rd_nxt;
            prior  <= rd_prv;
            state  <= (count == CW'(1)) ? S_COMMIT : S_DEL_A;
          end
        end
        S_INS_A: begin
          state <= empty ? S_COMMIT : S_INS_B;
        end
        S_INS_B: begin
          state <= S_INS_C;
        end
        S_INS_C: begin
          state <= S_COMMIT;
        end
        S_DEL_A: begin
          state <= S_DEL_B;
        end
        S_DEL_B: begin
          state <= S_COMMIT;
        end
        S_COMMIT: begin
          res_status <= ST_OK;
          state      <= S_RESP;
          if (op_ins) begin
            count <= count + CW'(1);
            if (empty || pos == 6'd1) begin
              head <= nslot;
            end
          end else begin
            count <= count - CW'(1);
            if (count == CW'(1)) begin
              head <= '0;
            end else if (pos == 6'd1) begin
              head <= after;
            end
          end
        end
        S_RESP: begin
          if (out_free) begin
            rsp.status  <= res_status;
            rsp.count   <= 6'(count);
            rsp.element <= '0;
            rsp.last    <= 1'b1;
            state       <= S_IDLE;
          end
        end
        S_DISP: begin
          if (out_free) begin
            rsp.status  <= ST_OK;
            rsp.count   <= 6'(count);
            rsp.element <= rd_val;
            rsp.last    <= (rem == CW'(1));
            if (rem == CW'(1)) begin
              state <= S_IDLE;
            end else begin
              cur <= rd_nxt;
              rem <= rem - CW'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/pls_checker.sv -----
// Port-level assertions for the positional list store, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module pls_checker #(
  parameter int CAPACITY = pls_pkg::DEF_CAPACITY
) (
  input wire                 clk,
  input wire                 rst,
  input wire                 req_valid,
  input wire                 req_ready,
  input pls_pkg::in_word_t   req,
  input wire                 rsp_valid,
  input wire                 rsp_ready,
  input pls_pkg::out_word_t  rsp
);
  import pls_pkg::*;

  `ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "word not held")
  `ASSERT_IMPLY(a_err_last, rsp_valid && rsp.status != ST_OK, rsp.last && rsp.element == '0, "error word")
  `ASSERT_IMPLY(a_stream_busy, rsp_valid && !rsp.last, !req_ready, "request taken mid-stream")
  `ASSERT_IMPLY(a_count_bound, rsp_valid, 32'(rsp.count) <= CAPACITY, "count above capacity")
  `ASSERT_AFTER_RESET(a_reset_idle, !rsp_valid, "word valid right after reset")

endmodule

bind positional_list_store pls_checker #(.CAPACITY(CAPACITY)) u_pls_checker (.*);

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench of the positional list store: directed steps, random traffic, handshake idling.
`timescale 1ns / 100ps

module testbench;
  import pls_pkg::*;

  localparam int CAP = DEF_CAPACITY;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 60;
  localparam int PHASE_WORDS = 20;

  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t typed_rsp;
  } step_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  in_word_t  req = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  out_word_t rsp;

  logic signed [31:0] list_values[$];
  out_word_t          pending_rsp[$];
  step_t              steps[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int words_sent = 0;
  int rsp_checked = 0;
  int peak_fill = 0;
  int full_hits = 0;
  int invalid_hits = 0;
  int cycle_count = 0;

  positional_list_store i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words outstanding", cycle_count,
               pending_rsp.size());
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("MISMATCH %s: got %0h want %0h (response word %0d)", what, got, want,
             rsp_checked);
  endtask

  task automatic check_rsp(input out_word_t got);
    out_word_t want;
    if (pending_rsp.size() == 0) begin
      report_mismatch("unexpected word", got.element, 0);
    end else begin
      want = pending_rsp.pop_front();
      if (got.status !== want.status)
        report_mismatch("status", 32'(got.status), 32'(want.status));
      if (got.count !== want.count)
        report_mismatch("count", 32'(got.count), 32'(want.count));
      if (got.element !== want.element)
        report_mismatch("element", got.element, want.element);
      if (got.last !== want.last)
        report_mismatch("last", 32'(got.last), 32'(want.last));
    end
    rsp_checked++;
  endtask

  always @(negedge clk) begin
    if (!rst && rsp_valid && rsp_ready) check_rsp(rsp);
  end

  function automatic void model_list_op(input in_word_t w, ref out_word_t res[$]);
    out_word_t r;
    int p;
    int n;
    p = int'(w.position);
    n = list_values.size();
    r = '0;
    r.last = 1'b1;
    res.delete();
    case (w.kind)
      KIND_INSERT: begin
        if (p < 1 || p > n + 1) begin
          r.status = ST_INVALID;
          invalid_hits++;
        end else if (n >= CAP) begin
          r.status = ST_FULL;
          full_hits++;
        end else begin
          list_values.insert(p - 1, w.value);
          r.status = ST_OK;
        end
        r.count = 6'(list_values.size());
        res.push_back(r);
      end
      KIND_DELETE: begin
        if (p < 1 || p > n) begin
          r.status = ST_INVALID;
          invalid_hits++;
        end else begin
          list_values.delete(p - 1);
          r.status = ST_OK;
        end
        r.count = 6'(list_values.size());
        res.push_back(r);
      end
      KIND_DISPLAY: begin
        r.status = ST_OK;
        r.count = 6'(n);
        if (n == 0) begin
          res.push_back(r);
        end else begin
          for (int i = 0; i < n; i++) begin
            r.element = list_values[i];
            r.last = (i == n - 1);
            res.push_back(r);
          end
        end
      end
      default: ;
    endcase
    if (list_values.size() > peak_fill) peak_fill = list_values.size();
  endfunction

  task automatic send_word(input in_word_t w, input bit typed, input out_word_t typed_rsp);
    out_word_t preds[$];
    bit go;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= w;
    do begin
      @(negedge clk);
      go = req_valid && req_ready;
      @(posedge clk);
    end while (!go);
    words_sent++;
    model_list_op(w, preds);
    if (typed && preds.size() == 1) preds[0] = typed_rsp;
    foreach (preds[i]) pending_rsp.push_back(preds[i]);
  endtask

  task automatic drain_responses();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_rsp.size() != 0);
  endtask

  function automatic void add_step(input logic [1:0] k, input int p, input logic [31:0] v,
                                   input bit typed, input logic [1:0] st, input int cnt);
    step_t s;
    s.w.kind = k;
    s.w.position = 6'(p);
    s.w.value = v;
    s.typed = typed;
    s.typed_rsp = '0;
    s.typed_rsp.status = st;
    s.typed_rsp.count = 6'(cnt);
    s.typed_rsp.last = 1'b1;
    steps.push_back(s);
  endfunction

  function automatic in_word_t make_random_word(input int ins_pct);
    in_word_t w;
    int r;
    int n;
    n = list_values.size();
    r = $urandom_range(99);
    w.value = $urandom;
    w.position = 6'($urandom_range(63));
    if (r < 3) begin
      w.kind = KIND_UNUSED;
    end else if (r < 10) begin
      w.kind = KIND_DISPLAY;
    end else if ($urandom_range(99) < ins_pct) begin
      w.kind = KIND_INSERT;
      if ($urandom_range(99) < 85) w.position = 6'($urandom_range(n + 1, 1));
    end else begin
      w.kind = KIND_DELETE;
      if (n > 0 && $urandom_range(99) < 85) w.position = 6'($urandom_range(n, 1));
    end
    return w;
  endfunction

  function automatic in_word_t make_insert(input int p);
    in_word_t w;
    w.kind = KIND_INSERT;
    w.position = 6'(p);
    w.value = $urandom;
    return w;
  endfunction

  initial begin
    int send_pct[4];
    int stall_pct[4];
    int ins_pct[4];
    send_pct = '{0, 83, 0, 7};
    stall_pct = '{0, 0, 83, 7};
    ins_pct = '{75, 50, 40, 55};

    add_step(KIND_DISPLAY, 0, 32'h0, 1, ST_OK, 0);
    add_step(KIND_DELETE, 1, 32'h0, 1, ST_INVALID, 0);
    add_step(KIND_DELETE, 0, 32'h0, 1, ST_INVALID, 0);
    add_step(KIND_INSERT, 0, 32'h5, 1, ST_INVALID, 0);
    add_step(KIND_INSERT, 2, 32'h6, 1, ST_INVALID, 0);
    add_step(KIND_INSERT, 63, 32'hffffffff, 1, ST_INVALID, 0);
    add_step(KIND_INSERT, 1, 32'h7fffffff, 1, ST_OK, 1);
    add_step(KIND_INSERT, 2, 32'h80000000, 1, ST_OK, 2);
    add_step(KIND_INSERT, 1, 32'h0, 1, ST_OK, 3);
    add_step(KIND_INSERT, 3, 32'hffffffff, 1, ST_OK, 4);
    add_step(KIND_INSERT, 5, 32'h55555555, 1, ST_OK, 5);
    add_step(KIND_INSERT, 7, 32'h1, 1, ST_INVALID, 5);
    add_step(KIND_DISPLAY, 0, 32'h0, 0, ST_OK, 0);
    add_step(KIND_UNUSED, 63, 32'hffffffff, 0, ST_OK, 0);
    add_step(KIND_DELETE, 6, 32'h0, 1, ST_INVALID, 5);
    add_step(KIND_DELETE, 1, 32'h0, 1, ST_OK, 4);
    add_step(KIND_DELETE, 4, 32'h0, 1, ST_OK, 3);
    add_step(KIND_DELETE, 2, 32'h0, 1, ST_OK, 2);
    add_step(KIND_DISPLAY, 0, 32'h0, 0, ST_OK, 0);
    add_step(KIND_INSERT, 3, 32'haaaaaaaa, 1, ST_OK, 3);
    add_step(KIND_DELETE, 1, 32'h0, 1, ST_OK, 2);
    add_step(KIND_DELETE, 2, 32'h0, 1, ST_OK, 1);
    add_step(KIND_DELETE, 1, 32'h0, 1, ST_OK, 0);
    add_step(KIND_DISPLAY, 63, 32'h12345678, 1, ST_OK, 0);
    add_step(KIND_INSERT, 1, 32'h0000ffff, 1, ST_OK, 1);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (steps[i]) send_word(steps[i].w, steps[i].typed, steps[i].typed_rsp);

    for (int ph = 0; ph < 4; ph++) begin
      drain_responses();
      send_idle_pct = send_pct[ph];
      recv_stall_pct = stall_pct[ph];
      if (ph == 2) begin
        while (list_values.size() < CAP)
          send_word(make_insert($urandom_range(list_values.size() + 1, 1)), 0, '0);
        send_word(make_insert(1), 0, '0);
        send_word(make_insert(CAP + 1), 0, '0);
        send_word(make_insert(CAP + 2), 0, '0);
        send_word(make_random_word(0) , 0, '0);
      end
      repeat (PHASE_WORDS) send_word(make_random_word(ins_pct[ph]), 0, '0);
    end

    drain_responses();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d request words and checked %0d response words over four idling phases",
             words_sent, rsp_checked);
    $display("Store peaked at %0d entries; %0d full and %0d invalid-position rejections",
             peak_fill, full_hits, invalid_hits);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
